// File: sv/mic_pkg.sv
// ----------------------------------------------------------------------------
// mic_pkg: shared types and constants for the magnetometer iron calibration
// Widths, Q16 hard-iron offsets and soft-iron matrices of both sensors.
// ----------------------------------------------------------------------------
package mic_pkg;

  localparam int RAW_W             = 16;   // raw sample width
  localparam int CW                = 30;   // scaled Q16 sample with offset
  localparam int COEF_W            = 18;   // Q16 matrix coefficient
  localparam int PROD_W            = CW + COEF_W;
  localparam int ACC_W             = PROD_W; // row sum stays well inside
  localparam int ACC_FRAC          = 32;
  localparam int OUT_W             = 24;
  localparam int SQ_W              = 2 * OUT_W - 1;
  localparam int MAG_W             = 24;
  localparam int SUM_W             = 2 * MAG_W;
  localparam int REM_W             = MAG_W + 2;
  localparam int NUM_AXES          = 3;
  localparam int OUT_FRAC_BITS_DEF = 10;

  localparam logic signed [CW-1:0]    Q_SCALE     = 30'sd9830;
  localparam logic signed [ACC_W-1:0] ACC_OUT_MAX = 48'sd8388607;
  localparam logic signed [ACC_W-1:0] ACC_OUT_MIN = -48'sd8388608;

  typedef logic signed [CW-1:0]    axis_t;
  typedef logic signed [OUT_W-1:0] field_t;
  typedef logic        [SQ_W-1:0]  square_t;

  typedef struct packed {
    logic valid;
    logic sel;
  } mic_ctl_t;

  // Hard-iron offsets, Q16 uT, indexed [sensor][axis]
  localparam logic signed [CW-1:0] HARD_IRON [2][NUM_AXES] = '{
    '{-30'sd131072,  30'sd98304,  -30'sd196608},
    '{ 30'sd65536,  -30'sd163840,  30'sd131072}
  };

  // Soft-iron matrices, Q16, indexed [sensor][row][column]
  localparam logic signed [COEF_W-1:0] SOFT_IRON [2][NUM_AXES][NUM_AXES] = '{
    '{ '{18'sd66847,  18'sd655,   18'sd328},
       '{18'sd655,    18'sd64225, 18'sd524},
       '{18'sd328,    18'sd524,   18'sd68813} },
    '{ '{18'sd64881, -18'sd1311,  18'sd655},
       '{-18'sd1311,  18'sd67502, -18'sd328},
       '{18'sd655,   -18'sd328,   18'sd63570} }
  };

endpackage

// File: sv/mic_lane.sv
// ----------------------------------------------------------------------------
// mic_lane: one soft-iron matrix row
// Multiplies the scaled sample by one matrix row, rounds, saturates and
// squares the resulting axis for the magnitude.
// ----------------------------------------------------------------------------
module mic_lane #(
  parameter int OUT_FRAC_BITS = mic_pkg::OUT_FRAC_BITS_DEF,
  parameter int ROW           = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mic_pkg::mic_ctl_t ctl_i,
  input  mic_pkg::axis_t    c_i [mic_pkg::NUM_AXES],
  output logic              valid_o,
  output mic_pkg::field_t   field_o,
  output mic_pkg::square_t  sq_o
);
  import mic_pkg::*;

  localparam int SH = ACC_FRAC - OUT_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (SH - 1);

  logic signed [PROD_W-1:0] prod_r [NUM_AXES];
  logic signed [PROD_W-1:0] prod_nxt [NUM_AXES];
  logic                     va_r, vb_r, vc_r;
  field_t                   field_r, field_nxt, field_c_r;
  square_t                  sq_r, sq_nxt;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  shifted;
  logic signed [2*OUT_W-1:0] sq_full;

  // products of this row
  always_comb begin
    for (int j = 0; j < NUM_AXES; j++) begin
      prod_nxt[j] = PROD_W'(c_i[j]) * PROD_W'(SOFT_IRON[ctl_i.sel][ROW][j]);
    end
  end

  // sum, round to nearest (ties up), saturate
  always_comb begin
    acc     = prod_r[0] + prod_r[1] + prod_r[2] + HALF;
    shifted = acc >>> SH;
    if (shifted > ACC_OUT_MAX) begin
      field_nxt = field_t'(ACC_OUT_MAX);
    end else if (shifted < ACC_OUT_MIN) begin
      field_nxt = field_t'(ACC_OUT_MIN);
    end else begin
      field_nxt = shifted[OUT_W-1:0];
    end
  end

  always_comb begin
    sq_full = (2*OUT_W)'(field_r) * (2*OUT_W)'(field_r);
    sq_nxt  = sq_full[SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= ctl_i.valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r    <= prod_nxt;
    field_r   <= field_nxt;
    field_c_r <= field_r;
    sq_r      <= sq_nxt;
  end

  assign valid_o = vc_r;
  assign field_o = field_c_r;
  assign sq_o    = sq_r;

endmodule

// File: sv/mic_merge.sv
// ----------------------------------------------------------------------------
// mic_merge: magnitude merge stage
// Sums the lane squares and takes the floor square root, one result bit
// per pipeline stage, carrying the axis values alongside.
// ----------------------------------------------------------------------------
module mic_merge (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   valid_i,
  input  mic_pkg::field_t        field_i [mic_pkg::NUM_AXES],
  input  mic_pkg::square_t       sq_i [mic_pkg::NUM_AXES],
  output logic                   valid_o,
  output mic_pkg::field_t        field_o [mic_pkg::NUM_AXES],
  output logic [mic_pkg::MAG_W-1:0] mag_o
);
  import mic_pkg::*;

  logic [SUM_W-1:0] n_r    [MAG_W+1];
  logic [REM_W-1:0] rem_r  [MAG_W+1];
  logic [MAG_W-1:0] root_r [MAG_W+1];
  logic             v_r    [MAG_W+1];
  field_t           f_r    [MAG_W+1][NUM_AXES];

  logic [SUM_W-1:0] n_nxt    [MAG_W+1];
  logic [REM_W-1:0] rem_nxt  [MAG_W+1];
  logic [MAG_W-1:0] root_nxt [MAG_W+1];

  // stage 0 loads the sum of squares; stage i+1 settles one root bit
  always_comb begin
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    n_nxt[0]    = SUM_W'(sq_i[0]) + SUM_W'(sq_i[1]) + SUM_W'(sq_i[2]);
    rem_nxt[0]  = '0;
    root_nxt[0] = '0;
    rem_sh      = '0;
    trial       = '0;
    for (int i = 0; i < MAG_W; i++) begin
      rem_sh = {rem_r[i][REM_W-3:0], n_r[i][2*(MAG_W-1-i) +: 2]};
      trial  = {root_r[i], 2'b01};
      n_nxt[i+1] = n_r[i];
      if (rem_sh >= trial) begin
        rem_nxt[i+1]  = rem_sh - trial;
        root_nxt[i+1] = {root_r[i][MAG_W-2:0], 1'b1};
      end else begin
        rem_nxt[i+1]  = rem_sh;
        root_nxt[i+1] = {root_r[i][MAG_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= MAG_W; i++) begin
        v_r[i] <= 1'b0;
      end
    end else begin
      v_r[0] <= valid_i;
      for (int i = 0; i < MAG_W; i++) begin
        v_r[i+1] <= v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    f_r[0] <= field_i;
    for (int i = 0; i < MAG_W; i++) begin
      f_r[i+1] <= f_r[i];
    end
  end

  assign valid_o = v_r[MAG_W];
  assign field_o = f_r[MAG_W];
  assign mag_o   = root_r[MAG_W];

endmodule

// File: sv/magnetometer_iron_calibration.sv
// ----------------------------------------------------------------------------
// magnetometer_iron_calibration: hard- and soft-iron compensation
// Scales a raw three-axis sample to uT, removes the hard-iron offset,
// applies the soft-iron matrix and reports the corrected field and magnitude.
// ----------------------------------------------------------------------------
// A request is taken on every cycle that start is high; busy never rises,
// so requests may follow one another with no gap. Each request gives exactly
// one result, shown for a single cycle with out_valid high, after it has
// passed one scaling stage, three stages in each matrix-row lane and the
// 25-stage magnitude merge, which loads the sum and then settles one
// square-root bit per stage. The block keeps no state between requests.
// The receiver cannot stall: capture the result on the cycle that
// out_valid is high or it is lost. Axes are in units of 2^-OUT_FRAC_BITS
// uT, rounded to nearest with ties upwards and saturated to 24 bits; the
// magnitude is the floor square root of the sum of the squared output axes.
// ----------------------------------------------------------------------------
module magnetometer_iron_calibration #(
  parameter int OUT_FRAC_BITS = mic_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_sensor,
  input  logic signed [mic_pkg::RAW_W-1:0]   in_raw_x,
  input  logic signed [mic_pkg::RAW_W-1:0]   in_raw_y,
  input  logic signed [mic_pkg::RAW_W-1:0]   in_raw_z,
  output logic                               out_valid,
  output logic signed [mic_pkg::OUT_W-1:0]   out_field_x,
  output logic signed [mic_pkg::OUT_W-1:0]   out_field_y,
  output logic signed [mic_pkg::OUT_W-1:0]   out_field_z,
  output logic        [mic_pkg::MAG_W-1:0]   out_field_magnitude
);
  import mic_pkg::*;

  logic signed [RAW_W-1:0] raw [NUM_AXES];
  axis_t                   c_r   [NUM_AXES];
  axis_t                   c_nxt [NUM_AXES];
  mic_ctl_t                ctl_r;
  logic                    lane_valid [NUM_AXES];
  field_t                  lane_field [NUM_AXES];
  square_t                 lane_sq    [NUM_AXES];
  field_t                  merge_field [NUM_AXES];

  // Pipelined throughout: never hold off a request.
  assign busy = 1'b0;

  assign raw[0] = in_raw_x;
  assign raw[1] = in_raw_y;
  assign raw[2] = in_raw_z;

  // Scale to Q16 uT (0.15 uT per LSB) and apply the sensor's hard-iron offset.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      c_nxt[a] = CW'(raw[a]) * Q_SCALE + HARD_IRON[in_sensor][a];
    end
  end

  // Advance the request valid under reset; carry the sensor number with the
  // sample for coefficient lookup.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= start & ~busy;
    end
    ctl_r.sel <= in_sensor;
    c_r       <= c_nxt;
  end

  // One lane per matrix row, all fed the same scaled sample.
  for (genvar r = 0; r < NUM_AXES; r++) begin : g_lane
    mic_lane #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS),
      .ROW           (r)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   (ctl_r),
      .c_i     (c_r),
      .valid_o (lane_valid[r]),
      .field_o (lane_field[r]),
      .sq_o    (lane_sq[r])
    );
  end

  // Combine the lanes: sum of squares, square root, aligned axis values.
  mic_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (lane_valid[0] & lane_valid[1] & lane_valid[2]),
    .field_i (lane_field),
    .sq_i    (lane_sq),
    .valid_o (out_valid),
    .field_o (merge_field),
    .mag_o   (out_field_magnitude)
  );

  assign out_field_x = merge_field[0];
  assign out_field_y = merge_field[1];
  assign out_field_z = merge_field[2];

endmodule
